// ===== design/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbc_pkg : shared types and constants for the hashed block cache lookup
// Field widths, opcode and status codes, and the buffer entry layout.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int BUCKETS_DEF = 13;

    localparam int OP_W   = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int IDX_W  = 5;
    localparam int TIME_W = 32;
    localparam int ST_W   = 2;
    localparam int REF_W  = 8;
    // Holds any bucket number for up to 64 buckets.
    localparam int BKT_W  = 6;

    localparam logic [REF_W-1:0] REFS_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_COUNT_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block;
        logic [BKT_W-1:0]  bucket;
        logic [REF_W-1:0]  refs;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] result_index;
        logic             was_hit;
        logic             needs_read;
    } t_rsp;

endpackage

// ===== design/hbc_if.sv =====
// ----------------------------------------------------------------------------
// hbc_if : request and response channels of the block cache lookup
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hbc_req_if;
    logic                        valid;
    logic                        ready;
    logic [hbc_pkg::OP_W-1:0]    opcode;
    logic [hbc_pkg::DEV_W-1:0]   device_id;
    logic [hbc_pkg::BLK_W-1:0]   block_number;
    logic [hbc_pkg::IDX_W-1:0]   entry_index;
    logic [hbc_pkg::TIME_W-1:0]  current_time;

    modport source (output valid, opcode, device_id, block_number, entry_index,
                    current_time, input ready);
    modport sink   (input valid, opcode, device_id, block_number, entry_index,
                    current_time, output ready);
endinterface

interface hbc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hbc_pkg::ST_W-1:0]    status;
    logic [hbc_pkg::IDX_W-1:0]   result_index;
    logic                        was_hit;
    logic                        needs_read;

    modport source (output valid, status, result_index, was_hit, needs_read,
                    input ready);
    modport sink   (input valid, status, result_index, was_hit, needs_read,
                    output ready);
endinterface

// ===== design/hbc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hbc_mod_unit : remainder of a block number by the bucket count
// Byte fold by constant weights, then reciprocal multiply; done rises together
// with the registered remainder.
// ----------------------------------------------------------------------------
module hbc_mod_unit #(
    parameter int BUCKETS = hbc_pkg::BUCKETS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hbc_pkg::BLK_W-1:0] i_value,
    output logic                      o_done,
    output logic [hbc_pkg::BKT_W-1:0] o_rem
);
    // Folded value: each byte weighted by 2^(8k) mod BUCKETS, sum below 2^16.
    localparam int SW = 16;
    // Reciprocal scale wide enough for an exact quotient of any SW-bit value.
    localparam int SH = SW + hbc_pkg::BKT_W;
    localparam int MW = SH + 1;
    localparam int PW = SW + MW;

    function automatic int byte_weight(input int k);
        int w;
        w = 1 % BUCKETS;
        for (int j = 0; j < 8 * k; j++) begin
            w = (w * 2) % BUCKETS;
        end
        return w;
    endfunction

    localparam logic [SW-1:0] W0 = SW'(byte_weight(0));
    localparam logic [SW-1:0] W1 = SW'(byte_weight(1));
    localparam logic [SW-1:0] W2 = SW'(byte_weight(2));
    localparam logic [SW-1:0] W3 = SW'(byte_weight(3));
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << SH) + longint'(BUCKETS) - longint'(1)) / longint'(BUCKETS));

    logic [SW-1:0]             r_sum;
    logic [SW-1:0]             r_x;
    logic [SW-1:0]             r_quo;
    logic [hbc_pkg::BKT_W-1:0] r_rem;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_done;
    logic [SW-1:0]             fold;
    logic [PW-1:0]             prod;
    logic [SW-1:0]             rem_full;

    always_comb begin
        fold     = SW'(i_value[7:0]) * W0 + SW'(i_value[15:8]) * W1
                 + SW'(i_value[23:16]) * W2 + SW'(i_value[31:24]) * W3;
        prod     = PW'(r_sum) * PW'(RECIP);
        rem_full = r_x - r_quo * SW'(BUCKETS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
            if (i_start) begin
                r_sum <= fold;
            end
            if (r_v1) begin
                r_x   <= r_sum;
                r_quo <= prod[SH +: SW];
            end
            if (r_v2) begin
                r_rem <= rem_full[hbc_pkg::BKT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== design/hbc_entry_store.sv =====
// ----------------------------------------------------------------------------
// hbc_entry_store : buffer entry memory with per-entry written flags
// One write and one registered read per cycle; unwritten entries read zero.
// ----------------------------------------------------------------------------
module hbc_entry_store #(
    parameter int ENTRIES = hbc_pkg::ENTRIES_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output hbc_pkg::t_entry o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  hbc_pkg::t_entry i_wr_data
);
    hbc_pkg::t_entry    r_mem [ENTRIES];
    hbc_pkg::t_entry    r_rd_q;
    logic [ENTRIES-1:0] r_written;
    logic               r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    // An entry never written reads as all zero.
    assign o_rd_data = r_rd_written ? r_rd_q : '0;

endmodule

// ===== design/hashed_block_cache_lru_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_block_cache_lru_lookup_unit : disk block buffer cache lookup
// Hashed buckets with timestamp LRU recycling of free buffer entries.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Payload
//  -------   ---  ---------            -------
//  i_req     in   i_req.valid/ready    opcode, device_id, block_number,
//                                      entry_index, current_time
//  o_rsp     out  o_rsp.valid/ready    status, result_index, was_hit, needs_read
//
//  A get first waits for the bucket remainder, then one memory read port
//  scans every entry, one per cycle, feeding a single match/LRU compare.
//  Release, pin and unpin do one read, one write back, one load.
//  An out-of-range entry index skips the write back and changes nothing.
//  One request is in flight at a time; i_req.ready is high only when idle.
//  A finished result waits in the output register while the next request
//  is taken; a stalled o_rsp holds the sequencer until the register frees.
//  Reset (i_rst_n low, synchronous) clears all entries at once.
// ----------------------------------------------------------------------------
module hashed_block_cache_lru_lookup_unit #(
    parameter int ENTRIES = hbc_pkg::ENTRIES_DEF,
    parameter int BUCKETS = hbc_pkg::BUCKETS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbc_req_if.sink    i_req,
    hbc_rsp_if.source  o_rsp
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = AW + 1;
    localparam int DW = hbc_pkg::BKT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_GET_WB,
        S_OP_WB,
        S_DONE
    } t_state;

    t_state r_state;

    // Captured request
    hbc_pkg::t_opcode             r_op;
    logic [hbc_pkg::DEV_W-1:0]    r_dev;
    logic [hbc_pkg::BLK_W-1:0]    r_blk;
    logic [hbc_pkg::IDX_W-1:0]    r_idx;
    logic [hbc_pkg::TIME_W-1:0]   r_now;

    // Scan pipeline and search results
    logic [CW-1:0]                r_rd_cnt;
    logic                         r_cmp_vld;
    logic [AW-1:0]                r_cmp_idx;
    logic                         r_hit;
    logic [AW-1:0]                r_hit_idx;
    hbc_pkg::t_entry              r_hit_ent;
    logic                         r_found;
    logic [AW-1:0]                r_best_idx;
    logic [hbc_pkg::BKT_W-1:0]    r_best_dist;
    logic [hbc_pkg::TIME_W-1:0]   r_best_stamp;

    // Result and output register
    hbc_pkg::t_rsp                r_res;
    hbc_pkg::t_rsp                n_res;
    hbc_pkg::t_rsp                r_out;
    logic                         r_out_valid;

    logic                         req_xfer;
    logic                         rsp_xfer;
    logic                         idx_in_range;
    logic                         scan_issue;
    logic                         mod_start;
    logic                         mod_done;
    logic [hbc_pkg::BKT_W-1:0]    home;

    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    hbc_pkg::t_entry              rd_data;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    hbc_pkg::t_entry              wr_data;

    logic [DW-1:0]                dist_sum;
    logic [DW-1:0]                dist_red;
    logic [hbc_pkg::BKT_W-1:0]    bkt_dist;
    logic                         is_match;
    logic                         is_free;
    logic                         is_better;

    assign req_xfer     = i_req.valid && i_req.ready;
    assign rsp_xfer     = o_rsp.valid && o_rsp.ready;
    assign idx_in_range = 32'(i_req.entry_index) < 32'(ENTRIES);
    assign scan_issue   = (r_state == S_SCAN) && (r_rd_cnt < CW'(ENTRIES));
    assign mod_start    = req_xfer && (i_req.opcode == hbc_pkg::OP_GET);

    // Read port: the target entry at request transfer, else the scan pointer.
    assign rd_en   = (req_xfer && (i_req.opcode != hbc_pkg::OP_GET) && idx_in_range)
                     || scan_issue;
    assign rd_addr = (r_state == S_IDLE) ? AW'(i_req.entry_index) : r_rd_cnt[AW-1:0];

    hbc_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_req.block_number),
        .o_done  (mod_done),
        .o_rem   (home)
    );

    hbc_entry_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Shared compare unit: tag match, and bucket distance plus stamp age for
    // picking the free entry to recycle. Both bucket numbers are below BUCKETS,
    // so one conditional subtract wraps the distance.
    always_comb begin
        dist_sum  = DW'(rd_data.bucket) + DW'(BUCKETS) - DW'(home);
        dist_red  = (dist_sum >= DW'(BUCKETS)) ? dist_sum - DW'(BUCKETS) : dist_sum;
        bkt_dist  = dist_red[hbc_pkg::BKT_W-1:0];
        is_match  = (rd_data.device == r_dev) && (rd_data.block == r_blk);
        is_free   = (rd_data.refs == '0);
        is_better = !r_found || (bkt_dist < r_best_dist)
                    || ((bkt_dist == r_best_dist) && (rd_data.stamp < r_best_stamp));
    end

    // Write back and result formation.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_hit_idx;
        wr_data = r_hit_ent;
        n_res   = '0;
        case (r_state)
            S_GET_WB: begin
                if (r_hit) begin
                    n_res.result_index = hbc_pkg::IDX_W'(r_hit_idx);
                    n_res.was_hit      = 1'b1;
                    if (r_hit_ent.refs == hbc_pkg::REFS_MAX) begin
                        n_res.status = hbc_pkg::ST_COUNT_ERR;
                    end else begin
                        wr_en            = 1'b1;
                        wr_data.refs     = r_hit_ent.refs + hbc_pkg::REF_W'(1);
                        wr_data.stamp    = r_now;
                        wr_data.valid    = 1'b1;
                        n_res.needs_read = !r_hit_ent.valid;
                    end
                end else if (r_found) begin
                    wr_en              = 1'b1;
                    wr_addr            = r_best_idx;
                    wr_data.valid      = 1'b1;
                    wr_data.device     = r_dev;
                    wr_data.block      = r_blk;
                    wr_data.bucket     = home;
                    wr_data.refs       = hbc_pkg::REF_W'(1);
                    wr_data.stamp      = r_now;
                    n_res.result_index = hbc_pkg::IDX_W'(r_best_idx);
                    n_res.needs_read   = 1'b1;
                end else begin
                    n_res.status = hbc_pkg::ST_NO_FREE;
                end
            end
            S_OP_WB: begin
                wr_addr            = AW'(r_idx);
                wr_data            = rd_data;
                n_res.result_index = r_idx;
                case (r_op)
                    hbc_pkg::OP_PIN: begin
                        if (rd_data.refs == hbc_pkg::REFS_MAX) begin
                            n_res.status = hbc_pkg::ST_COUNT_ERR;
                        end else begin
                            wr_en        = 1'b1;
                            wr_data.refs = rd_data.refs + hbc_pkg::REF_W'(1);
                        end
                    end
                    hbc_pkg::OP_RELEASE, hbc_pkg::OP_UNPIN: begin
                        if (rd_data.refs == '0) begin
                            n_res.status = hbc_pkg::ST_COUNT_ERR;
                        end else begin
                            wr_en        = 1'b1;
                            wr_data.refs = rd_data.refs - hbc_pkg::REF_W'(1);
                            // Release also marks the entry as just used.
                            if (r_op == hbc_pkg::OP_RELEASE) begin
                                wr_data.stamp = r_now;
                            end
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            // Load the output register when it is free; otherwise drop it
            // once the consumer takes the transfer.
            if ((r_state == S_DONE) && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (rsp_xfer) begin
                r_out_valid <= 1'b0;
            end

            // Advance the scan pipeline: read data lands in the cycle after issue.
            r_cmp_vld <= scan_issue;
            r_cmp_idx <= r_rd_cnt[AW-1:0];
            if (scan_issue) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if (r_cmp_vld) begin
                // Keep the lowest-index match.
                if (is_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_hit_ent <= rd_data;
                end
                // Keep the nearest bucket, then oldest stamp; ties keep the lower index.
                if (is_free && is_better) begin
                    r_found      <= 1'b1;
                    r_best_idx   <= r_cmp_idx;
                    r_best_dist  <= bkt_dist;
                    r_best_stamp <= rd_data.stamp;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (req_xfer) begin
                        r_op  <= hbc_pkg::t_opcode'(i_req.opcode);
                        r_dev <= i_req.device_id;
                        r_blk <= i_req.block_number;
                        r_idx <= i_req.entry_index;
                        r_now <= i_req.current_time;
                        if (i_req.opcode == hbc_pkg::OP_GET) begin
                            r_state <= S_MOD;
                        end else if (idx_in_range) begin
                            r_state <= S_OP_WB;
                        end else begin
                            // Out-of-range target: echo the index, change nothing.
                            r_res <= '{status:       hbc_pkg::ST_OK,
                                       result_index: i_req.entry_index,
                                       was_hit:      1'b0,
                                       needs_read:   1'b0};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_rd_cnt <= '0;
                        r_hit    <= 1'b0;
                        r_found  <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!scan_issue && !r_cmp_vld) begin
                        r_state <= S_GET_WB;
                    end
                end
                S_GET_WB, S_OP_WB: begin
                    r_res   <= n_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.result_index = r_out.result_index;
    assign o_rsp.was_hit      = r_out.was_hit;
    assign o_rsp.needs_read   = r_out.needs_read;

endmodule

// ===== design/hbc_checker.sv =====
// ----------------------------------------------------------------------------
// hbc_checker : port-level checks for the block cache lookup
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module hbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    hbc_req_if.sink   i_req,
    hbc_rsp_if.source o_rsp
);

    // A response that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid)
        else $error("response dropped while stalled");

    // Only one request is in flight: busy right after a request transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while previous one in flight");

    // No free buffer reports nothing else.
    a_no_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == hbc_pkg::ST_NO_FREE)
        |-> (o_rsp.result_index == '0) && !o_rsp.was_hit && !o_rsp.needs_read)
        else $error("no-free response carries payload");

    // A count error never asks for a disk read.
    a_err_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == hbc_pkg::ST_COUNT_ERR) |-> !o_rsp.needs_read)
        else $error("count error with read request");

endmodule

bind hashed_block_cache_lru_lookup_unit hbc_checker u_hbc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);

// ===== tb/tb_hashed_block_cache_lru_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hashed_block_cache_lru_lookup_unit : self-checking bench for the lookup
// Drive get, release, pin and unpin requests with bursty valid and a stalling
// response side. Keep an image of every buffer entry and derive each
// response from it. Compare responses in order, field by field.
// ----------------------------------------------------------------------------
module tb_hashed_block_cache_lru_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1550;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 500;
    localparam int KEYS          = 48;
    localparam logic [hbc_pkg::BLK_W-1:0] NBKT = hbc_pkg::BUCKETS_DEF;

    typedef struct packed {
        hbc_pkg::t_opcode           op;
        logic [hbc_pkg::DEV_W-1:0]  dev;
        logic [hbc_pkg::BLK_W-1:0]  blk;
        logic [hbc_pkg::IDX_W-1:0]  idx;
        logic [hbc_pkg::TIME_W-1:0] now;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    hbc_req_if req_if();
    hbc_rsp_if rsp_if();

    hashed_block_cache_lru_lookup_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Image of the buffer entries, updated at every request transfer.
    logic [hbc_pkg::DEV_W-1:0]  img_dev   [hbc_pkg::ENTRIES_DEF] = '{default: '0};
    logic [hbc_pkg::BLK_W-1:0]  img_blk   [hbc_pkg::ENTRIES_DEF] = '{default: '0};
    logic [hbc_pkg::REF_W-1:0]  img_refs  [hbc_pkg::ENTRIES_DEF] = '{default: '0};
    logic [hbc_pkg::TIME_W-1:0] img_stamp [hbc_pkg::ENTRIES_DEF] = '{default: '0};
    logic                       img_valid [hbc_pkg::ENTRIES_DEF] = '{default: 1'b0};

    t_request      request_backlog[$];
    hbc_pkg::t_rsp awaited_outcomes[$];

    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int err_count    = 0;
    int cycle_count  = 0;

    // Generator bookkeeping: reference counts the generator knows it may drop,
    // a pool of recurring device/block keys, and the running tick count.
    int                         held [hbc_pkg::ENTRIES_DEF];
    logic [hbc_pkg::DEV_W-1:0]  key_dev [KEYS];
    logic [hbc_pkg::BLK_W-1:0]  key_blk [KEYS];
    logic [hbc_pkg::TIME_W-1:0] tick = 32'd100;

    logic        hold_off      = 1'b0;
    logic [15:0] ready_pattern = '1;
    int          pattern_pos   = 0;
    int          mode_left     = 0;

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Lookup outcome: apply one request to the entry image and return the
    // response the block must give for it.
    // ------------------------------------------------------------------------
    function automatic hbc_pkg::t_rsp lookup_outcome(t_request rq);
        hbc_pkg::t_rsp             r;
        logic [hbc_pkg::BLK_W-1:0] home;
        logic [hbc_pkg::BLK_W-1:0] bkt_dist;
        logic [hbc_pkg::BLK_W-1:0] best_dist;
        int                        best;
        bit                        found;
        int                        i;
        r         = '0;
        found     = 1'b0;
        best      = 0;
        best_dist = '0;
        if (rq.op == hbc_pkg::OP_GET) begin
            // A hit takes the lowest matching entry, including the all-zero
            // entries left by reset.
            for (i = 0; i < hbc_pkg::ENTRIES_DEF; i++) begin
                if (img_dev[i] == rq.dev && img_blk[i] == rq.blk) begin
                    r.was_hit      = 1'b1;
                    r.result_index = hbc_pkg::IDX_W'(i);
                    if (img_refs[i] == hbc_pkg::REFS_MAX) begin
                        r.status = hbc_pkg::ST_COUNT_ERR;
                    end else begin
                        img_refs[i]++;
                        img_stamp[i] = rq.now;
                        r.needs_read = !img_valid[i];
                        img_valid[i] = 1'b1;
                        r.status     = hbc_pkg::ST_OK;
                    end
                    return r;
                end
            end
            // Miss: nearest bucket upward from home wins, then oldest stamp,
            // then lowest index.
            home = rq.blk % NBKT;
            for (i = 0; i < hbc_pkg::ENTRIES_DEF; i++) begin
                if (img_refs[i] == '0) begin
                    bkt_dist = (img_blk[i] % NBKT + NBKT - home) % NBKT;
                    if (!found || bkt_dist < best_dist ||
                        (bkt_dist == best_dist && img_stamp[i] < img_stamp[best])) begin
                        found     = 1'b1;
                        best      = i;
                        best_dist = bkt_dist;
                    end
                end
            end
            if (!found) begin
                r.status = hbc_pkg::ST_NO_FREE;
                return r;
            end
            img_dev[best]   = rq.dev;
            img_blk[best]   = rq.blk;
            img_stamp[best] = rq.now;
            img_refs[best]  = hbc_pkg::REF_W'(1);
            img_valid[best] = 1'b1;
            r.status        = hbc_pkg::ST_OK;
            r.result_index  = hbc_pkg::IDX_W'(best);
            r.needs_read    = 1'b1;
        end else begin
            r.result_index = rq.idx;
            r.status       = hbc_pkg::ST_OK;
            if (rq.op == hbc_pkg::OP_PIN) begin
                if (img_refs[rq.idx] == hbc_pkg::REFS_MAX) begin
                    r.status = hbc_pkg::ST_COUNT_ERR;
                end else begin
                    img_refs[rq.idx]++;
                end
            end else if (img_refs[rq.idx] == '0) begin
                r.status = hbc_pkg::ST_COUNT_ERR;
            end else begin
                img_refs[rq.idx]--;
                if (rq.op == hbc_pkg::OP_RELEASE) begin
                    img_stamp[rq.idx] = rq.now;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    task automatic queue_request(hbc_pkg::t_opcode op, int unsigned dev,
                                 logic [hbc_pkg::BLK_W-1:0] blk, int unsigned idx,
                                 logic [hbc_pkg::TIME_W-1:0] now);
        t_request rq;
        rq.op  = op;
        rq.dev = hbc_pkg::DEV_W'(dev);
        rq.blk = blk;
        rq.idx = hbc_pkg::IDX_W'(idx);
        rq.now = now;
        request_backlog.push_back(rq);
        issued_cnt++;
    endtask

    // Hold until every queued request has been transferred; the entry image
    // is then current.
    task automatic wait_accepted();
        while (accepted_cnt != issued_cnt) @(posedge i_clk);
    endtask

    // Advance the tick mostly by small steps (zero steps give equal stamps),
    // now and then jump anywhere in the 32-bit range.
    function automatic logic [hbc_pkg::TIME_W-1:0] next_tick();
        if ($urandom_range(0, 49) == 0) begin
            tick = $urandom;
        end else begin
            tick += $urandom_range(0, 3);
        end
        return tick;
    endfunction

    task automatic refresh_key(int k);
        key_dev[k] = ($urandom_range(0, 99) < 75)
                     ? hbc_pkg::DEV_W'($urandom_range(0, 3))
                     : hbc_pkg::DEV_W'($urandom_range(0, 255));
        key_blk[k] = ($urandom_range(0, 99) < 60)
                     ? hbc_pkg::BLK_W'($urandom_range(0, 40))
                     : hbc_pkg::BLK_W'($urandom);
    endtask

    task automatic get_key(int k);
        queue_request(hbc_pkg::OP_GET, key_dev[k], key_blk[k], $urandom_range(0, 31),
                      next_tick());
    endtask

    function automatic int pick_held();
        int cand[$];
        int i;
        for (i = 0; i < hbc_pkg::ENTRIES_DEF; i++) begin
            if (held[i] > 0) cand.push_back(i);
        end
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps. A transfer
    // updates the entry image and queues the awaited response.
    // ------------------------------------------------------------------------
    int       gap_left   = 0;
    int       burst_left = 0;
    t_request offered;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid        <= 1'b0;
            req_if.opcode       <= hbc_pkg::OP_GET;
            req_if.device_id    <= '0;
            req_if.block_number <= '0;
            req_if.entry_index  <= '0;
            req_if.current_time <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                awaited_outcomes.push_back(lookup_outcome(offered));
                accepted_cnt++;
            end
            // Advance only when the bus is free or its item just transferred.
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    offered = request_backlog.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.opcode       <= offered.op;
                    req_if.device_id    <= offered.dev;
                    req_if.block_number <= offered.blk;
                    req_if.entry_index  <= offered.idx;
                    req_if.current_time <= offered.now;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A quarter of the bursts run straight into the next.
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: a 16-bit stall pattern replayed, redrawn every so often
    // as all ready, random, or mostly stalled. The hold-off overrides it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            if ($urandom_range(0, 99) < 35) begin
                ready_pattern <= '1;
            end else if ($urandom_range(0, 99) < 60) begin
                ready_pattern <= 16'($urandom);
            end else begin
                ready_pattern <= 16'($urandom & $urandom & $urandom);
            end
            mode_left <= $urandom_range(16, 128);
        end else begin
            mode_left <= mode_left - 1;
        end
        pattern_pos  <= (pattern_pos + 1) % 16;
        rsp_if.ready <= i_rst_n && !hold_off && ready_pattern[pattern_pos];
    end

    // Hold the response side off for a long stretch while requests are still
    // queued, so the output register fills and the request side stalls.
    initial begin : receiver_hold
        while (accepted_cnt < HOLD_START || request_backlog.size() < 4) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Response monitor: compare every transfer with the oldest awaited one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_monitor
        hbc_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_outcomes.size() == 0) begin
                report_mismatch($sformatf("response with none outstanding: status %0d index %0d",
                                          rsp_if.status, rsp_if.result_index));
            end else begin
                want = awaited_outcomes.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status: got %0d, want %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.result_index !== want.result_index)
                    report_mismatch($sformatf("result_index: got %0d, want %0d",
                                              rsp_if.result_index, want.result_index));
                if (rsp_if.was_hit !== want.was_hit)
                    report_mismatch($sformatf("was_hit: got %0d, want %0d",
                                              rsp_if.was_hit, want.was_hit));
                if (rsp_if.needs_read !== want.needs_read)
                    report_mismatch($sformatf("needs_read: got %0d, want %0d",
                                              rsp_if.needs_read, want.needs_read));
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("FAIL hashed_block_cache_lru_lookup_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                        n;
        int                        e;
        int                        k;
        int                        j;
        int                        pick;
        int                        order[$];
        bit                        saturated;
        logic [hbc_pkg::DEV_W-1:0] sat_dev;
        logic [hbc_pkg::BLK_W-1:0] sat_blk;

        i_rst_n   = 1'b0;
        saturated = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed part -------------------------------------------------
        // Device 0 block 0 matches the zeroed entries: hit on entry 0 with a
        // read needed, then a plain hit.
        queue_request(hbc_pkg::OP_GET, 0, 0, 0, 5);
        queue_request(hbc_pkg::OP_GET, 0, 0, 31, 6);
        // Top of every range: miss and retag, then hit.
        queue_request(hbc_pkg::OP_GET, 255, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        queue_request(hbc_pkg::OP_GET, 255, 32'hFFFF_FFFF, 31, 7);
        // Drop a count that is already zero: underflow on unpin and release.
        queue_request(hbc_pkg::OP_UNPIN, 0, 0, 31, 8);
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 31, 9);
        // Pin then release, the release stamping the largest tick.
        queue_request(hbc_pkg::OP_PIN, 255, 32'hFFFF_FFFF, 31, 10);
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 31, 32'hFFFF_FFFF);
        // Drain entry 0 and go one past zero.
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 0, 0);
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 0, 0);
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 0, 12);
        // Free entry 1, which now sits in a bucket away from the rest.
        queue_request(hbc_pkg::OP_UNPIN, 0, 0, 1, 13);
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 1, 14);
        // Same block, other device: a miss, not a hit.
        queue_request(hbc_pkg::OP_GET, 1, 0, 0, 15);
        // Home bucket empty of free entries: search steps up and wraps.
        queue_request(hbc_pkg::OP_GET, 0, 1, 0, 16);
        queue_request(hbc_pkg::OP_GET, 0, 13, 0, 17);
        queue_request(hbc_pkg::OP_GET, 8'h80, 32'h8000_0000, 16, 18);
        queue_request(hbc_pkg::OP_GET, 8'h7F, 32'h7FFF_FFFF, 15, 19);
        queue_request(hbc_pkg::OP_PIN, 0, 0, 2, 20);
        queue_request(hbc_pkg::OP_UNPIN, 0, 0, 2, 21);
        queue_request(hbc_pkg::OP_RELEASE, 0, 0, 16, 22);
        wait_accepted();

        // --- Random part ---------------------------------------------------
        for (k = 0; k < KEYS; k++) refresh_key(k);

        while (issued_cnt < ITEM_TARGET) begin
            wait_accepted();
            for (e = 0; e < hbc_pkg::ENTRIES_DEF; e++) held[e] = img_refs[e];
            pick = $urandom_range(0, 99);

            if (!saturated && issued_cnt >= 700) begin
                // Walk one entry to the count ceiling: overflow on pin and on
                // a hit, then back down to zero and one underflow.
                saturated = 1'b1;
                e       = $urandom_range(0, hbc_pkg::ENTRIES_DEF - 1);
                sat_dev = img_dev[e];
                sat_blk = img_blk[e];
                j = 0;
                while (img_dev[j] != sat_dev || img_blk[j] != sat_blk) j++;
                repeat (int'(hbc_pkg::REFS_MAX - img_refs[j]))
                    queue_request(hbc_pkg::OP_PIN, 0, 0, j, next_tick());
                queue_request(hbc_pkg::OP_PIN, 0, 0, j, next_tick());
                queue_request(hbc_pkg::OP_GET, sat_dev, sat_blk, j, next_tick());
                queue_request(hbc_pkg::OP_UNPIN, 0, 0, j, next_tick());
                queue_request(hbc_pkg::OP_GET, sat_dev, sat_blk, j, next_tick());
                queue_request(hbc_pkg::OP_GET, sat_dev, sat_blk, j, next_tick());
                repeat (int'(hbc_pkg::REFS_MAX) + 1)
                    queue_request(hbc_pkg::OP_RELEASE, 0, 0, j, next_tick());
            end else if (pick < 55) begin
                // Normal use: gets on recurring keys, drops of held counts.
                n = $urandom_range(10, 40);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    e    = pick_held();
                    if (pick < 45 || e < 0) begin
                        get_key($urandom_range(0, KEYS - 1));
                    end else if (pick < 88) begin
                        queue_request(($urandom_range(0, 2) == 0) ? hbc_pkg::OP_UNPIN
                                                                  : hbc_pkg::OP_RELEASE,
                                      $urandom_range(0, 255), $urandom, e, next_tick());
                        held[e]--;
                    end else if (pick < 94) begin
                        queue_request(hbc_pkg::OP_PIN, $urandom_range(0, 255), $urandom, e,
                                      next_tick());
                        held[e]++;
                    end else begin
                        queue_request(hbc_pkg::OP_GET, $urandom_range(0, 255), $urandom,
                                      $urandom_range(0, 31), next_tick());
                    end
                end
            end else if (pick < 67) begin
                // Grab entries until none is free.
                n = $urandom_range(28, 40);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0) begin
                        get_key($urandom_range(0, KEYS - 1));
                    end else begin
                        queue_request(hbc_pkg::OP_GET, $urandom_range(0, 255), $urandom,
                                      $urandom_range(0, 31), next_tick());
                    end
                end
            end else if (pick < 85) begin
                // Drop up to three counts per held entry in shuffled order.
                order.delete();
                for (e = 0; e < hbc_pkg::ENTRIES_DEF; e++) begin
                    for (j = 0; j < held[e] && j < 3; j++) order.push_back(e);
                end
                while (order.size() != 0) begin
                    j = $urandom_range(0, order.size() - 1);
                    e = order[j];
                    order.delete(j);
                    queue_request(($urandom_range(0, 3) == 0) ? hbc_pkg::OP_UNPIN
                                                              : hbc_pkg::OP_RELEASE,
                                  $urandom_range(0, 255), $urandom, e, next_tick());
                end
                if ($urandom_range(0, 2) == 0)
                    queue_request(hbc_pkg::OP_RELEASE, 0, 0, $urandom_range(0, 31),
                                  next_tick());
            end else begin
                // Noise: any opcode, any field values.
                n = $urandom_range(5, 20);
                repeat (n) begin
                    queue_request(hbc_pkg::t_opcode'($urandom_range(0, 3)),
                                  $urandom_range(0, 255), $urandom, $urandom_range(0, 31),
                                  $urandom);
                end
                refresh_key($urandom_range(0, KEYS - 1));
                refresh_key($urandom_range(0, KEYS - 1));
            end
        end

        // --- End of run ----------------------------------------------------
        wait_accepted();
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS hashed_block_cache_lru_lookup_unit");
        end else begin
            $display("FAIL hashed_block_cache_lru_lookup_unit");
        end
        $finish;
    end

endmodule
